// ----- src/fbba_pkg.sv -----
// Shared constants and types for the free-block bitmap allocator.
package fbba_pkg;

    localparam int BLOCK_COUNT   = 4096;
    localparam int MAP_WORD_BITS = 64;
    localparam int MAP_WORDS     = (BLOCK_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WADDR_W       = $clog2(MAP_WORDS);
    localparam int BITPOS_W      = $clog2(MAP_WORD_BITS);
    localparam int SCAN_CNT_W    = $clog2(MAP_WORDS + 1);
    localparam int BLK_W         = 12;
    localparam int BN_W          = 13;
    localparam int MODE_W        = 2;
    localparam int STATUS_W      = 2;

    localparam logic [MODE_W-1:0] MODE_FIND    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE    = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef logic [MAP_WORD_BITS-1:0] map_word_t;
    typedef logic [WADDR_W-1:0]       waddr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_DONE
    } fbba_state_t;

endpackage

// ----- src/fbba_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module fbba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/free_block_bitmap_allocator.sv -----
// Top level of the free-block bitmap allocator: sequencer, map memory and result register.
//
// Usage: an item on the input channel (in_valid, in_stall, mode, block_number) asks
// for one of three operations on a map of 4096 blocks, one bit per block, 1 = free.
// Find returns the lowest free block, reserve marks a block used, and free marks it
// free. Every item gives exactly one result on the output channel (out_valid,
// out_stall, found_block, status).
// Timing: the block works on one item at a time and raises in_stall while busy.
// Find reads one 64-bit map word per cycle from the map memory and tests it with a
// priority encoder, and stops at the first word that holds a free block. Reserve and
// free are one read-modify-write of the map memory. An out-of-range block number
// goes straight to the done state without touching the map memory. The next item
// is taken in the cycle after the result is loaded into the output register.
// Reset: every block is free at once; per-word valid flags make unwritten words read
// as all free, so no clearing pass is needed.
// Stall: a result waits in the output register while out_stall is high; a new item
// can be accepted meanwhile, but its result waits until the register is taken.
module free_block_bitmap_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [fbba_pkg::MODE_W-1:0]   mode,
    input  logic [fbba_pkg::BN_W-1:0]     block_number,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [fbba_pkg::BLK_W-1:0]    found_block,
    output logic [fbba_pkg::STATUS_W-1:0] status
);

    import fbba_pkg::*;

    localparam map_word_t TOP_BIT = {1'b1, {(MAP_WORD_BITS - 1){1'b0}}};

    fbba_state_t             state_reg, state_next;
    logic [MODE_W-1:0]       op_mode_reg, op_mode_next;
    logic [BLK_W-1:0]        bn_reg, bn_next;
    logic [SCAN_CNT_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic                    chk_valid_reg, chk_valid_next;
    waddr_t                  chk_addr_reg, chk_addr_next;
    logic [MAP_WORDS-1:0]    vld_reg, vld_next;
    logic [BLK_W-1:0]        res_block_reg, res_block_next;
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;
    logic                    out_valid_reg, out_valid_next;
    logic [BLK_W-1:0]        found_block_reg, found_block_next;
    logic [STATUS_W-1:0]     status_reg, status_next;

    logic                    ram_we;
    waddr_t                  ram_waddr;
    map_word_t               ram_wdata;
    logic                    ram_re;
    waddr_t                  ram_raddr;
    map_word_t               ram_rdata;

    logic                    accept;
    logic                    out_free;
    logic                    bn_in_range;
    waddr_t                  rmw_addr;
    map_word_t               rd_word;
    map_word_t               bit_mask;
    logic                    word_has_free;
    logic [BITPOS_W-1:0]     first_pos;
    logic [WADDR_W+BITPOS_W-1:0] scan_blk;
    logic                    scan_blk_ok;
    logic                    scan_last;

    fbba_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept      = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign bn_in_range = 32'(block_number) < BLOCK_COUNT;
    assign rmw_addr    = WADDR_W'(bn_reg >> BITPOS_W);
    assign bit_mask    = TOP_BIT >> bn_reg[BITPOS_W-1:0];

    // Words never written since reset read as all free.
    always_comb
    begin
        if (state_reg == ST_RMW_WR)
        begin
            rd_word = vld_reg[rmw_addr] ? ram_rdata : '1;
        end
        else
        begin
            rd_word = vld_reg[chk_addr_reg] ? ram_rdata : '1;
        end
    end

    always_comb
    begin
        word_has_free = 1'b0;
        first_pos     = '0;
        for (int k = MAP_WORD_BITS - 1; k >= 0; k--)
        begin
            if (rd_word[MAP_WORD_BITS-1-k])
            begin
                word_has_free = 1'b1;
                first_pos     = BITPOS_W'(k);
            end
        end
    end

    assign scan_blk    = {chk_addr_reg, first_pos};
    assign scan_blk_ok = 32'(scan_blk) < BLOCK_COUNT;
    assign scan_last   = 32'(chk_addr_reg) == MAP_WORDS - 1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_RESERVE || mode == MODE_FREE)
                    begin
                        state_next = bn_in_range ? ST_RMW_RD : ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (chk_valid_reg && (word_has_free || scan_last))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RMW_RD:
            begin
                state_next = ST_RMW_WR;
            end
            ST_RMW_WR:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall         = state_reg != ST_IDLE;
        op_mode_next     = op_mode_reg;
        bn_next          = bn_reg;
        scan_cnt_next    = scan_cnt_reg;
        chk_valid_next   = 1'b0;
        chk_addr_next    = chk_addr_reg;
        vld_next         = vld_reg;
        res_block_next   = res_block_reg;
        res_status_next  = res_status_reg;
        found_block_next = found_block_reg;
        status_next      = status_reg;
        out_valid_next   = out_valid_reg && out_stall;
        ram_we           = 1'b0;
        ram_waddr        = rmw_addr;
        ram_wdata        = rd_word;
        ram_re           = 1'b0;
        ram_raddr        = rmw_addr;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_mode_next    = mode;
                    bn_next         = BLK_W'(block_number);
                    scan_cnt_next   = '0;
                    res_block_next  = '0;
                    res_status_next = STATUS_RANGE;
                end
            end
            ST_SCAN:
            begin
                if (32'(scan_cnt_reg) < MAP_WORDS)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = scan_cnt_reg[WADDR_W-1:0];
                    chk_valid_next = 1'b1;
                    chk_addr_next  = scan_cnt_reg[WADDR_W-1:0];
                    scan_cnt_next  = scan_cnt_reg + 1'b1;
                end
                if (chk_valid_reg && (word_has_free || scan_last))
                begin
                    chk_valid_next = 1'b0;
                    if (word_has_free && scan_blk_ok)
                    begin
                        res_block_next  = BLK_W'(scan_blk);
                        res_status_next = STATUS_OK;
                    end
                    else
                    begin
                        res_block_next  = '0;
                        res_status_next = STATUS_FULL;
                    end
                end
            end
            ST_RMW_RD:
            begin
                ram_re = 1'b1;
            end
            ST_RMW_WR:
            begin
                ram_we = 1'b1;
                if (op_mode_reg == MODE_RESERVE)
                begin
                    ram_wdata = rd_word & ~bit_mask;
                end
                else
                begin
                    ram_wdata = rd_word | bit_mask;
                end
                vld_next[rmw_addr] = 1'b1;
                res_block_next     = bn_reg;
                res_status_next    = STATUS_OK;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    found_block_next = res_block_reg;
                    status_next      = res_status_reg;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chk_valid_reg <= 1'b0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_mode_reg     <= op_mode_next;
        bn_reg          <= bn_next;
        scan_cnt_reg    <= scan_cnt_next;
        chk_addr_reg    <= chk_addr_next;
        res_block_reg   <= res_block_next;
        res_status_reg  <= res_status_next;
        found_block_reg <= found_block_next;
        status_reg      <= status_next;
    end

    assign out_valid   = out_valid_reg;
    assign found_block = found_block_reg;
    assign status      = status_reg;

`ifndef NO_ASSERTIONS
    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("Result loaded outside the done state.");

    a_check_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> state_reg == ST_SCAN)
        else $error("Word check pending outside the scan.");

    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RMW_WR |-> $past(state_reg) == ST_RMW_RD)
        else $error("Map write without a preceding read.");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid) |=> state_reg != ST_IDLE)
        else $error("Accepted item did not start an operation.");
`endif

endmodule

// ----- sim/block_map_model_pkg.sv -----
// Scoreboard class that tracks the expected free-block map and checks allocator results.
package block_map_model_pkg;

    import fbba_pkg::*;

    typedef struct packed {
        logic [BLK_W-1:0]    blk;
        logic [STATUS_W-1:0] st;
    } alloc_result_t;

    class block_map_tracker;

        bit            free_bits [BLOCK_COUNT];
        alloc_result_t expected_q [$];
        int            mismatches;

        function new();
            foreach (free_bits[i])
                free_bits[i] = 1'b1;
            mismatches = 0;
        endfunction

        function int lowest_free();
            int n;
            n = 0;
            while (n < BLOCK_COUNT && !free_bits[n])
                n++;
            return n;
        endfunction

        function void note_request(logic [MODE_W-1:0] m, logic [BN_W-1:0] b);
            alloc_result_t r;
            int            lo;
            r.blk = '0;
            r.st  = STATUS_OK;
            if (m == MODE_RESERVE || m == MODE_FREE)
            begin
                if (b >= BLOCK_COUNT)
                    r.st = STATUS_RANGE;
                else
                begin
                    free_bits[b] = (m == MODE_FREE);
                    r.blk = b[BLK_W-1:0];
                end
            end
            else
            begin
                lo = lowest_free();
                if (lo < BLOCK_COUNT)
                    r.blk = lo[BLK_W-1:0];
                else
                    r.st = STATUS_FULL;
            end
            expected_q.push_back(r);
        endfunction

        function void log_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH: %s", msg);
        endfunction

        function void check_result(logic [BLK_W-1:0] blk, logic [STATUS_W-1:0] st);
            alloc_result_t exp;
            if (expected_q.size() == 0)
            begin
                log_mismatch($sformatf("result found_block=%0d status=%0d with no item pending",
                                       blk, st));
                return;
            end
            exp = expected_q.pop_front();
            if (blk !== exp.blk)
                log_mismatch($sformatf("found_block expected %0d actual %0d", exp.blk, blk));
            if (st !== exp.st)
                log_mismatch($sformatf("status expected %0d actual %0d", exp.st, st));
        endfunction

    endclass

endpackage

// ----- sim/tb_free_block_bitmap_allocator.sv -----
// Testbench for the free-block bitmap allocator with random traffic and scoreboard checks.
module tb_free_block_bitmap_allocator;

    import fbba_pkg::*;
    import block_map_model_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1000;
    localparam int FILL_BLOCKS  = 256;
    localparam int DRAIN_CYCLES = 100;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [MODE_W-1:0]   mode;
    logic [BN_W-1:0]     block_number;
    logic                out_valid;
    logic                out_stall;
    logic [BLK_W-1:0]    found_block;
    logic [STATUS_W-1:0] status;

    block_map_tracker map_model = new();

    int burst_left;
    int stall_kind = 0;
    int stall_left = 0;

    free_block_bitmap_allocator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .block_number (block_number),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found_block  (found_block),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            map_model.note_request(mode, block_number);
        if (rst_n && out_valid && !out_stall)
            map_model.check_result(found_block, status);
    end

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_kind = $urandom_range(0, 3);
            stall_left = (stall_kind == 3) ? $urandom_range(1, 12) : $urandom_range(20, 300);
        end
        stall_left = stall_left - 1;
        case (stall_kind)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= 1'b1;
        endcase
    end

    task automatic send_item(input logic [MODE_W-1:0] m, input logic [BN_W-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                3:       gap = $urandom_range(20, 80);
                default: gap = $urandom_range(1, 6);
            endcase
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left = burst_left - 1;
        in_valid     <= 1'b1;
        mode         <= m;
        block_number <= b;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic random_item(input int reserve_weight);
        int                pick;
        int                near;
        logic [MODE_W-1:0] m;
        logic [BN_W-1:0]   b;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            m = MODE_FIND;
        else if (pick < 25 + reserve_weight)
            m = MODE_RESERVE;
        else if (pick < 95)
            m = MODE_FREE;
        else
            m = MODE_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            near = map_model.lowest_free() + $urandom_range(0, 7);
            if (near >= 2)
                near = near - 2;
            b = near[BN_W-1:0];
        end
        else if (pick < 85)
            b = BN_W'($urandom_range(0, BLOCK_COUNT - 1));
        else
            b = BN_W'($urandom_range(0, (1 << BN_W) - 1));
        send_item(m, b);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = MODE_FIND;
        block_number = '0;
        burst_left   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(MODE_FIND, '0);
        send_item(MODE_UNUSED, 13'd8191);
        send_item(MODE_RESERVE, 13'd0);
        send_item(MODE_FIND, 13'd0);
        send_item(MODE_RESERVE, 13'd0);
        send_item(MODE_FREE, 13'd1);
        send_item(MODE_FREE, 13'd0);
        send_item(MODE_FIND, 13'd8191);
        send_item(MODE_RESERVE, 13'd4095);
        send_item(MODE_FREE, 13'd4095);
        send_item(MODE_RESERVE, 13'd4096);
        send_item(MODE_FREE, 13'd4096);
        send_item(MODE_RESERVE, 13'd8191);
        send_item(MODE_FREE, 13'd8191);
        send_item(MODE_RESERVE, 13'd63);
        send_item(MODE_RESERVE, 13'd64);
        send_item(MODE_FREE, 13'd63);
        send_item(MODE_FIND, 13'd0);

        for (int i = 0; i < RANDOM_ITEMS / 2; i++)
            random_item(40);

        for (int n = 0; n < FILL_BLOCKS; n++)
            send_item(MODE_RESERVE, n[BN_W-1:0]);
        send_item(MODE_FIND, 13'd0);
        send_item(MODE_UNUSED, 13'd0);
        send_item(MODE_FREE, 13'd4095);
        send_item(MODE_FIND, 13'd0);
        send_item(MODE_RESERVE, 13'd4095);
        send_item(MODE_FIND, 13'd0);

        for (int i = 0; i < RANDOM_ITEMS / 2; i++)
            random_item(20);

        in_valid <= 1'b0;
        while (map_model.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (map_model.mismatches == 0 && map_model.expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
src/fbba_pkg.sv
src/fbba_ram.sv
src/free_block_bitmap_allocator.sv
sim/block_map_model_pkg.sv
sim/tb_free_block_bitmap_allocator.sv
